>>> design/tfp_pkg.sv
`default_nettype none
package tfp_pkg;

    // Default sizes
    localparam int RING_DEPTH_DEF = 2048;
    localparam int MAX_PACKET_DEF = 64;

    // Field widths fixed by the interface
    localparam int BYTE_W      = 8;
    localparam int FREE_W      = 11;
    localparam int PKT_SIZE_W  = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    localparam logic [PKT_SIZE_W-1:0] PKT_SIZE_RESET = 7'd64;
    localparam logic                  LINK_CONFIGURED = 1'b1;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_KICK  = 1'b1
    } t_kind;

    typedef enum logic {
        RES_STATUS = 1'b0,
        RES_PACKET = 1'b1
    } t_res_kind;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;     // write item transferred: store byte if room, load status
        logic kick_start;  // kick taken: latch free count after the packet
        logic rd_en;       // read next ring byte, advance read pointer
        logic load_pkt;    // move the read byte into the output register
        logic last;        // loaded byte closes the packet
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register empty or being emptied this cycle
        logic empty;       // ring holds no byte
    } t_dp_status;

endpackage
`default_nettype wire

>>> design/tx_byte_fifo_packetizer_core.sv
`default_nettype none
// Transmit byte ring for a bulk IN endpoint. A write transfer (tuser 0) offers one
// byte; it is stored if the ring has room (one slot is always kept empty, so
// RING_DEPTH-1 bytes at most) and answers with one status transfer carrying the
// accepted flag and the free count. A kick transfer (tuser 1) pops up to
// packet_size bytes (clamped to 1..MAX_PACKET) as packet-byte transfers, oldest
// first, tlast on the final one, provided the link is configured, the endpoint is
// not busy and the ring is not empty; otherwise it yields nothing. Writes are taken
// one per cycle while the output side is not stalled. A taken kick reads its n bytes
// through the single registered read port of the ring, and they leave at one per
// cycle while the output is not stalled; the next item is taken only after the last
// byte is loaded. No input is taken while a packet is being sent or while a result
// waits and the output side is stalled. packet_size is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module tx_byte_fifo_packetizer_core #(
    parameter int RING_DEPTH = tfp_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = tfp_pkg::MAX_PACKET_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // [7:0] byte_in, [8] link_connected, [9] endpoint_busy, [15:10] zero
    input  wire logic [tfp_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] kind
    input  wire logic                            i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [0] accepted, [11:1] free_slots, [19:12] packet_byte, [23:20] zero
    output logic [tfp_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    // [0] result_kind
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tfp_pkg::PKT_SIZE_W-1:0]  i_cfg_data
);
    import tfp_pkg::*;

    localparam int N_W = $clog2(MAX_PACKET + 1);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [N_W-1:0]    pkt_len;
    logic              res_kind;
    logic              accepted;
    logic [FREE_W-1:0] free_slots;
    logic [BYTE_W-1:0] packet_byte;

    // Configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    tfp_ctrl #(
        .N_W (N_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_link     (i_s_axis_tdata[8]),
        .i_busy     (i_s_axis_tdata[9]),
        .i_status   (status),
        .i_pkt_len  (pkt_len),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    tfp_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET),
        .N_W        (N_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_pkt_len     (pkt_len),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_byte        (i_s_axis_tdata[BYTE_W-1:0]),
        .i_m_tready    (i_m_axis_tready),
        .o_m_valid     (o_m_axis_tvalid),
        .o_res_kind    (res_kind),
        .o_accepted    (accepted),
        .o_free_slots  (free_slots),
        .o_packet_byte (packet_byte),
        .o_packet_last (o_m_axis_tlast)
    );

    // Pack result fields, lowest first
    assign o_m_axis_tdata = {{(M_TDATA_W - 1 - FREE_W - BYTE_W){1'b0}},
                             packet_byte, free_slots, accepted};
    assign o_m_axis_tuser = res_kind;

`ifndef SYNTH
    // Only packet bytes may close a packet
    a_last_is_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == RES_PACKET)
        else $error("tlast on a status result");

    // A write transfer is answered by a status result in the next cycle
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_wr |=> o_m_axis_tvalid && (o_m_axis_tuser == RES_STATUS))
        else $error("write transfer without status result");

    // Input is held off once a packet starts
    a_kick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.kick_start |=> !o_s_axis_tready)
        else $error("input taken while a packet is in flight");
`endif

endmodule
`default_nettype wire

>>> design/tfp_datapath.sv
`default_nettype none
module tfp_datapath #(
    parameter int RING_DEPTH = tfp_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = tfp_pkg::MAX_PACKET_DEF,
    parameter int N_W        = $clog2(MAX_PACKET + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tfp_pkg::t_dp_cmd              i_cmd,
    output tfp_pkg::t_dp_status                o_status,
    output logic [N_W-1:0]                     o_pkt_len,
    input  wire logic                          i_cfg_valid,
    input  wire logic [tfp_pkg::PKT_SIZE_W-1:0] i_cfg_data,
    input  wire logic [tfp_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                          i_m_tready,
    output logic                               o_m_valid,
    output logic                               o_res_kind,
    output logic                               o_accepted,
    output logic [tfp_pkg::FREE_W-1:0]         o_free_slots,
    output logic [tfp_pkg::BYTE_W-1:0]         o_packet_byte,
    output logic                               o_packet_last
);
    import tfp_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int LW    = (N_W > PKT_SIZE_W) ? N_W : PKT_SIZE_W;
    localparam int CW    = (LW > PTR_W) ? LW : PTR_W;
    localparam int FW    = (PTR_W > FREE_W) ? PTR_W : FREE_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    logic [BYTE_W-1:0]     r_mem [RING_DEPTH];
    logic [BYTE_W-1:0]     r_rd_data;
    logic [PTR_W-1:0]      r_wptr, n_wptr;
    logic [PTR_W-1:0]      r_rptr, n_rptr;
    logic [PTR_W-1:0]      r_fill, n_fill;
    logic [PTR_W-1:0]      r_pkt_free;
    logic [PKT_SIZE_W-1:0] r_pkt_size;

    logic                  r_out_valid;
    logic                  r_out_kind;
    logic                  r_out_acc;
    logic [FREE_W-1:0]     r_out_free;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_last;

    logic                  full;
    logic                  wr_en;
    logic [PTR_W-1:0]      free_now;
    logic [PTR_W-1:0]      free_wr;
    logic [LW-1:0]         lim;
    logic [CW-1:0]         fill_c;
    logic [CW-1:0]         lim_c;

    always_comb begin
        full     = (r_fill == LAST_SLOT);
        wr_en    = i_cmd.load_wr && !full;
        free_now = LAST_SLOT - r_fill;
        free_wr  = free_now - PTR_W'(wr_en);

        // Clamp the packet size to 1..MAX_PACKET
        lim = LW'(r_pkt_size);
        if (lim == '0) begin
            lim = LW'(1);
        end
        if (lim > LW'(MAX_PACKET)) begin
            lim = LW'(MAX_PACKET);
        end
        fill_c    = CW'(r_fill);
        lim_c     = CW'(lim);
        o_pkt_len = (fill_c < lim_c) ? N_W'(fill_c) : N_W'(lim_c);

        n_wptr = r_wptr;
        if (wr_en) begin
            n_wptr = (r_wptr == LAST_SLOT) ? '0 : r_wptr + PTR_W'(1);
        end
        n_rptr = r_rptr;
        if (i_cmd.rd_en) begin
            n_rptr = (r_rptr == LAST_SLOT) ? '0 : r_rptr + PTR_W'(1);
        end
        n_fill = r_fill + PTR_W'(wr_en) - PTR_W'(i_cmd.rd_en);

        o_status.out_free = !r_out_valid || i_m_tready;
        o_status.empty    = (r_fill == '0);
    end

    // Ring storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_fill      <= '0;
            r_pkt_size  <= PKT_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
            if (i_cfg_valid) begin
                r_pkt_size <= i_cfg_data;
            end
            if (i_cmd.load_wr || i_cmd.load_pkt) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        logic [FW-1:0] fw_wr;
        logic [FW-1:0] fw_pkt;
        fw_wr  = FW'(free_wr);
        fw_pkt = FW'(r_pkt_free);
        if (i_cmd.kick_start) begin
            r_pkt_free <= free_now + PTR_W'(o_pkt_len);
        end
        if (i_cmd.load_wr) begin
            r_out_kind <= RES_STATUS;
            r_out_acc  <= !full;
            r_out_free <= fw_wr[FREE_W-1:0];
            r_out_byte <= '0;
            r_out_last <= 1'b0;
        end else if (i_cmd.load_pkt) begin
            r_out_kind <= RES_PACKET;
            r_out_acc  <= 1'b0;
            r_out_free <= fw_pkt[FREE_W-1:0];
            r_out_byte <= r_rd_data;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_res_kind    = r_out_kind;
    assign o_accepted    = r_out_acc;
    assign o_free_slots  = r_out_free;
    assign o_packet_byte = r_out_byte;
    assign o_packet_last = r_out_last;

endmodule
`default_nettype wire

>>> design/tfp_ctrl.sv
`default_nettype none
module tfp_ctrl #(
    parameter int N_W = $clog2(tfp_pkg::MAX_PACKET_DEF + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_kind,
    input  wire logic                 i_link,
    input  wire logic                 i_busy,
    input  wire tfp_pkg::t_dp_status  i_status,
    input  wire logic [N_W-1:0]       i_pkt_len,
    output logic                      o_s_tready,
    output tfp_pkg::t_dp_cmd          o_cmd
);
    import tfp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEND
    } t_state;

    t_state         r_state;
    logic [N_W-1:0] r_left;     // bytes still to be read from the ring
    logic           r_rd_pend;  // read data waiting for the output register

    logic accept;
    logic can_load;

    always_comb begin
        o_s_tready = (r_state == S_IDLE) && i_status.out_free;
        accept     = i_s_tvalid && o_s_tready;
        can_load   = (r_state == S_SEND) && r_rd_pend && i_status.out_free;

        o_cmd.load_wr    = accept && (i_kind == KIND_WRITE);
        o_cmd.kick_start = accept && (i_kind == KIND_KICK) && (i_link == LINK_CONFIGURED)
                           && !i_busy && !i_status.empty;
        o_cmd.rd_en      = (r_state == S_SEND) && (r_left != '0) && (!r_rd_pend || can_load);
        o_cmd.load_pkt   = can_load;
        o_cmd.last       = (r_left == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_rd_pend <= 1'b0;
                    if (o_cmd.kick_start) begin
                        r_left  <= i_pkt_len;
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (o_cmd.rd_en) begin
                        r_left    <= r_left - N_W'(1);
                        r_rd_pend <= 1'b1;
                    end else if (can_load) begin
                        r_rd_pend <= 1'b0;
                    end
                    if (can_load && o_cmd.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> tb/tx_byte_fifo_packetizer_core_tb.sv
module tx_byte_fifo_packetizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfp_pkg::*;

    // Worst case is far below this: about 500 items plus at most as many results,
    // each costing at most one long gap or stall from idle_len, plus one long hold.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned HOLD_AFTER  = 120;
    localparam int unsigned REPORT_MAX  = 10;

    // One input transfer: tuser carries kind, tdata the rest
    typedef struct packed {
        t_kind                kind;
        logic                 endpoint_busy;
        logic                 link_connected;
        logic [BYTE_W-1:0]    byte_in;
    } host_item_t;

    // One output transfer as the block should present it
    typedef struct packed {
        t_res_kind            res_kind;
        logic                 accepted;
        logic [FREE_W-1:0]    free_slots;
        logic [BYTE_W-1:0]    pkt_byte;
        logic                 pkt_last;
    } ring_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [PKT_SIZE_W-1:0] i_cfg_data = '0;

    tx_byte_fifo_packetizer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock: 1 ns high, 1 ns low
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted ring state
    // ------------------------------------------------------------------
    // The depth is 2**FREE_W, so the 11-bit pointers wrap on their own and
    // their difference is the fill level without any modulo.
    logic [BYTE_W-1:0]     ring_bytes [RING_DEPTH_DEF];
    logic [FREE_W-1:0]     wr_ptr = '0;
    logic [FREE_W-1:0]     rd_ptr = '0;
    logic [PKT_SIZE_W-1:0] pkt_size_reg = PKT_SIZE_RESET;

    host_item_t   pending_items[$];
    ring_result_t expected_results[$];

    host_item_t  cur_item = '0;
    bit          tx_taken = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_stall = 0;
    bit          long_hold_done = 1'b0;
    bit          idle_on = 1'b1;

    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Work out the transfers that one accepted item causes and queue them
    function automatic void predict_ring_results(input host_item_t it);
        logic [FREE_W-1:0] fill;
        logic [FREE_W-1:0] room;
        int unsigned       lim;
        int unsigned       n;
        ring_result_t      r;
        fill = wr_ptr - rd_ptr;
        room = FREE_W'(RING_DEPTH_DEF - 1) - fill;
        r = '0;
        if (it.kind == KIND_WRITE) begin
            r.res_kind = RES_STATUS;
            // One slot always stays empty, so zero room means full
            if (room != 0) begin
                ring_bytes[wr_ptr] = it.byte_in;
                wr_ptr = wr_ptr + FREE_W'(1);
                r.accepted = 1'b1;
                room = room - FREE_W'(1);
            end
            r.free_slots = room;
            expected_results.push_back(r);
            return;
        end
        // Refused kick: nothing leaves
        if (it.link_connected != LINK_CONFIGURED || it.endpoint_busy || fill == 0)
            return;
        lim = 32'(pkt_size_reg);
        if (lim == 0)
            lim = 1;
        if (lim > MAX_PACKET_DEF)
            lim = MAX_PACKET_DEF;
        n = (32'(fill) > lim) ? lim : 32'(fill);
        // Every byte of the packet reports the free count after the whole pop
        r.res_kind   = RES_PACKET;
        r.free_slots = room + FREE_W'(n);
        for (int unsigned i = 0; i < n; i++) begin
            r.pkt_byte = ring_bytes[rd_ptr];
            r.pkt_last = (i + 1 == n);
            rd_ptr = rd_ptr + FREE_W'(1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(input string field_name, input int unsigned want,
                                            input int unsigned seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_seen, field_name, want, seen);
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int unsigned idle_len(input bit may_be_zero);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (may_be_zero && r < 55)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender: accept at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_accept
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_ring_results(cur_item);
            items_taken++;
            tx_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : tx_drive
        logic vld;
        // Hold the current item until its transfer completes
        vld = i_s_axis_tvalid && !tx_taken;
        tx_taken = 1'b0;
        if (!vld && i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_items.size() != 0) begin
                cur_item = pending_items.pop_front();
                vld = 1'b1;
                tx_gap = idle_on ? idle_len(1'b1) : 0;
            end
        end
        i_s_axis_tvalid <= vld;
        i_s_axis_tuser  <= cur_item.kind;
        i_s_axis_tdata  <= S_TDATA_W'({cur_item.endpoint_busy, cur_item.link_connected,
                                       cur_item.byte_in});
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    // The long hold starts once the sender has a good backlog, so the output
    // register fills and the block must stall its input while items wait.
    always @(negedge i_clk) begin : rx_ready_gen
        logic rdy;
        rdy = 1'b1;
        if (!long_hold_done && items_taken >= HOLD_AFTER && pending_items.size() > 40) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rdy = 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            rdy = 1'b0;
            rx_stall--;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            rdy = 1'b0;
            rx_stall = idle_len(1'b0) - 1;
        end
        i_m_axis_tready <= rdy && i_rst_n;
    end

    // Compare each result transfer with the oldest prediction, field by field
    always @(posedge i_clk) begin : rx_check
        ring_result_t got;
        ring_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.res_kind   = t_res_kind'(o_m_axis_tuser);
            got.accepted   = o_m_axis_tdata[0];
            got.free_slots = o_m_axis_tdata[FREE_W:1];
            got.pkt_byte   = o_m_axis_tdata[FREE_W+BYTE_W:FREE_W+1];
            got.pkt_last   = o_m_axis_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending, tdata", 0, o_m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.res_kind !== want.res_kind)
                    report_mismatch("result_kind", want.res_kind, got.res_kind);
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", want.accepted, got.accepted);
                if (got.free_slots !== want.free_slots)
                    report_mismatch("free_slots", want.free_slots, got.free_slots);
                if (got.pkt_byte !== want.pkt_byte)
                    report_mismatch("packet_byte", want.pkt_byte, got.pkt_byte);
                if (got.pkt_last !== want.pkt_last)
                    report_mismatch("packet_last", want.pkt_last, got.pkt_last);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input t_kind k, input logic [BYTE_W-1:0] b, input logic link,
                             input logic busy);
        host_item_t it;
        it.kind           = k;
        it.byte_in        = b;
        it.link_connected = link;
        it.endpoint_busy  = busy;
        pending_items.push_back(it);
    endtask

    // Pause the sender until every predicted transfer has arrived, then let
    // a refused kick still in flight settle
    task automatic wait_until_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write packet_size; only called with the block idle
    task automatic load_pkt_size(input logic [PKT_SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        pkt_size_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    logic [PKT_SIZE_W-1:0] phase_sizes [6];

    initial begin : stimulus
        int unsigned counted;
        int unsigned run_len;
        t_kind       k;
        logic        link;
        logic        busy;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, packet_size at its reset value
        push_item(KIND_KICK, 8'h00, LINK_CONFIGURED, 1'b0);   // kick on an empty ring
        push_item(KIND_WRITE, 8'h00, 1'b0, 1'b0);
        push_item(KIND_WRITE, 8'hFF, 1'b1, 1'b1);
        push_item(KIND_WRITE, 8'hA5, 1'b0, 1'b1);
        push_item(KIND_WRITE, 8'h5A, 1'b1, 1'b0);
        push_item(KIND_KICK, 8'h00, 1'b0, 1'b0);              // link down
        push_item(KIND_KICK, 8'h00, LINK_CONFIGURED, 1'b1);   // endpoint busy
        push_item(KIND_KICK, 8'hFF, 1'b0, 1'b1);              // both
        push_item(KIND_KICK, 8'h00, LINK_CONFIGURED, 1'b0);   // sends all four bytes
        push_item(KIND_KICK, 8'h00, LINK_CONFIGURED, 1'b0);   // ring empty again
        push_item(KIND_WRITE, 8'h01, 1'b0, 1'b0);
        push_item(KIND_WRITE, 8'h80, 1'b0, 1'b0);
        push_item(KIND_WRITE, 8'h7F, 1'b0, 1'b0);
        push_item(KIND_KICK, 8'hFF, LINK_CONFIGURED, 1'b0);
        wait_until_drained();

        // Random phases: 0 saturates up to 1, 127 and 65 saturate down to 64
        phase_sizes = '{7'd1, 7'd0, PKT_SIZE_W'($urandom_range(2, 63)), 7'd127, 7'd65, 7'd64};
        foreach (phase_sizes[p]) begin
            load_pkt_size(phase_sizes[p]);
            // One phase runs without any idling on either side
            idle_on = (p != 2);
            counted = 0;
            while (counted < 55) begin
                if ($urandom_range(0, 99) < 80) begin
                    // Host write loop: a run of writes, then one kick
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                          : $urandom_range(1, 10);
                    repeat (run_len)
                        push_item(KIND_WRITE, BYTE_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    push_item(KIND_KICK, BYTE_W'($urandom_range(0, 255)), LINK_CONFIGURED,
                              1'b0);
                    counted += run_len + 1;
                end else begin
                    // Noise: any item at all
                    k    = t_kind'($urandom_range(0, 1));
                    link = 1'($urandom_range(0, 1));
                    busy = 1'($urandom_range(0, 1));
                    push_item(k, BYTE_W'($urandom_range(0, 255)), link, busy);
                    if (k == KIND_WRITE || (link == LINK_CONFIGURED && !busy))
                        counted++;
                end
            end
            wait_until_drained();
        end

        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            $display("%0d predicted results never arrived", expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> tx_byte_fifo_packetizer_core.f
design/tfp_pkg.sv
design/tfp_datapath.sv
design/tfp_ctrl.sv
design/tx_byte_fifo_packetizer_core.sv
tb/tx_byte_fifo_packetizer_core_tb.sv
